// File: src/pps_pkg.sv
package pps_pkg;

    // operation codes carried by the func field
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load_we;     // write the offered load word into its slot
        logic clear_best;  // start of a tick: forget the previous winner
        logic rd_en;       // read the next slot during the scan
        logic commit;      // apply the tick and present the result
    } t_pps_cmd;

    // datapath to controller
    typedef struct packed {
        logic last_addr;   // the slot being read is the final one
        logic out_free;    // result register can take a new word
    } t_pps_sts;

endpackage

// File: src/pps_ctrl.sv
module pps_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_func,
    output logic              o_in_ready,
    input  pps_pkg::t_pps_sts i_sts,
    output pps_pkg::t_pps_cmd o_cmd
);
    import pps_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_UPDATE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_func == FUNC_LOAD)) begin
                    o_cmd.load_we = 1'b1;
                end
                if (w_accept && (i_func == FUNC_TICK)) begin
                    o_cmd.clear_best = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (i_sts.last_addr) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last slot's word is judged this cycle
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: src/pps_datapath.sv
module pps_datapath #(
    parameter int SLOTS     = 8,
    parameter int TIME_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pps_pkg::t_pps_cmd i_cmd,
    output pps_pkg::t_pps_sts o_sts,
    input  logic [2:0]        i_slot,
    input  logic [15:0]       i_arrival,
    input  logic [15:0]       i_burst,
    input  logic [7:0]        i_priority_req,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [2:0]        o_run_slot,
    output logic              o_idle,
    output logic              o_finished,
    output logic [15:0]       o_time_now,
    output logic              o_all_done
);
    import pps_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WW = 16;
    localparam int PW = 8;
    localparam int MW = TIME_BITS + WW + PW;

    // slot table: {arrival, remaining work, priority}
    logic [MW-1:0]        r_mem [SLOTS];
    logic [SLOTS-1:0]     r_busy;
    logic [SLOTS-1:0]     n_busy;

    logic [IW-1:0]        r_addr;
    logic [MW-1:0]        r_rd;
    logic [IW-1:0]        r_rd_idx;
    logic                 r_rd_vld;

    logic                 r_found;
    logic [IW-1:0]        r_best;
    logic [TIME_BITS-1:0] r_best_arr;
    logic [WW-1:0]        r_best_work;
    logic [PW-1:0]        r_best_prio;

    logic [TIME_BITS-1:0] r_time;
    logic [TIME_BITS-1:0] n_time;
    logic                 r_out_valid;

    logic                 w_slot_ok;
    logic [IW-1:0]        w_ld_idx;
    logic [TIME_BITS-1:0] w_rd_arr;
    logic [WW-1:0]        w_rd_work;
    logic [PW-1:0]        w_rd_prio;
    logic                 w_cand;
    logic                 w_better;
    logic                 w_done_now;

    assign w_slot_ok = (32'(i_slot) < SLOTS);
    assign w_ld_idx  = IW'(i_slot);

    assign {w_rd_arr, w_rd_work, w_rd_prio} = r_rd;

    // ready job: work left and already arrived
    assign w_cand   = r_busy[r_rd_idx] && (w_rd_arr <= r_time);
    assign w_better = !r_found || (w_rd_prio > r_best_prio)
                   || ((w_rd_prio == r_best_prio) && (w_rd_arr < r_best_arr));

    assign w_done_now = r_found && (r_best_work == WW'(1));
    assign n_time     = (r_time == '1) ? r_time : r_time + 1'b1;

    assign o_sts.last_addr = (r_addr == IW'(SLOTS - 1));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we && w_slot_ok) begin
            r_mem[w_ld_idx] <= {TIME_BITS'(i_arrival), i_burst, i_priority_req};
        end else if (i_cmd.commit && r_found) begin
            r_mem[r_best] <= {r_best_arr, r_best_work - 1'b1, r_best_prio};
        end
        if (i_cmd.rd_en) begin
            r_rd     <= r_mem[r_addr];
            r_rd_idx <= r_addr;
        end
    end

    always_comb begin
        n_busy = r_busy;
        if (i_cmd.load_we && w_slot_ok) begin
            n_busy[w_ld_idx] = (i_burst != '0);
        end
        if (i_cmd.commit && w_done_now) begin
            n_busy[r_best] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= '0;
            r_time      <= '0;
            r_addr      <= '0;
            r_rd_vld    <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_rd_vld <= i_cmd.rd_en;
            if (i_cmd.clear_best) begin
                r_addr  <= '0;
                r_found <= 1'b0;
            end else begin
                if (i_cmd.rd_en) begin
                    r_addr <= r_addr + 1'b1;
                end
                if (r_rd_vld && w_cand && w_better) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.commit) begin
                r_time      <= n_time;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // winner payload
    always_ff @(posedge i_clk) begin
        if (r_rd_vld && w_cand && w_better) begin
            r_best      <= r_rd_idx;
            r_best_arr  <= w_rd_arr;
            r_best_work <= w_rd_work;
            r_best_prio <= w_rd_prio;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_run_slot <= r_found ? 3'(r_best) : 3'd0;
            o_idle     <= !r_found;
            o_finished <= w_done_now;
            o_time_now <= 16'(n_time);
            o_all_done <= ~|n_busy;
        end
    end

endmodule

// File: src/preemptive_priority_scheduler.sv
// preemptive priority scheduler over a table of SLOTS job slots. a load word
// (func 0) writes one slot's arrival time, work and priority in the cycle it
// is accepted and gives no result; a slot number not below SLOTS is dropped.
// a tick word (func 1) scans the table one slot per cycle through the single
// read port of the slot memory, keeping the best ready job (highest priority,
// then earliest arrival, then lowest slot), then decrements its work and
// advances time. a tick holds off the input through SLOTS memory reads, a
// state to judge the last word and a state to write back; write-back waits
// as long as an earlier result word is still untaken in the output register,
// so a stalled receiver lengthens the tick. once written back the result is
// held in that register, so new words are taken while it waits. the work-left
// flags live in flip-flops and clear at reset, so no clearing pass is needed
module preemptive_priority_scheduler #(
    parameter int SLOTS     = 8,
    parameter int TIME_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_func,
    input  logic [2:0]  i_slot,
    input  logic [15:0] i_arrival,
    input  logic [15:0] i_burst,
    input  logic [7:0]  i_priority_req,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_run_slot,
    output logic        o_idle,
    output logic        o_finished,
    output logic [15:0] o_time_now,
    output logic        o_all_done
);
    import pps_pkg::*;

    t_pps_cmd w_cmd;
    t_pps_sts w_sts;

    // sequencer: accept, scan, judge, write back
    pps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // slot table, running best, clock and result register
    pps_datapath #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_slot         (i_slot),
        .i_arrival      (i_arrival),
        .i_burst        (i_burst),
        .i_priority_req (i_priority_req),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_run_slot     (o_run_slot),
        .o_idle         (o_idle),
        .o_finished     (o_finished),
        .o_time_now     (o_time_now),
        .o_all_done     (o_all_done)
    );

endmodule

// File: src/pps_checker.sv
module pps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_func,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_run_slot,
    input logic        o_idle,
    input logic        o_finished
);

    // a pending result word is not withdrawn
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result word dropped before it was taken");

    // an accepted tick blocks the input as the scan begins
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_func) |=> !o_in_ready)
        else $error("input taken during a scan");

    // an idle tick serves nothing
    a_idle_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_idle) |-> (!o_finished && (o_run_slot == 3'd0)))
        else $error("idle tick reports a served slot");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (.*);

// File: tb/tb_preemptive_priority_scheduler.sv
`timescale 1ns / 100ps

module tb_preemptive_priority_scheduler;

    import pps_pkg::*;

    localparam int SLOTS       = 8;
    localparam int RAND_WORDS  = 2000;
    localparam int LONG_HOLD   = 300;      // receiver hold-off during the pressure window
    localparam int PRESS_WORDS = 40;       // back-to-back words offered while held off
    localparam int DRAIN       = 2 * SLOTS + 6;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int MAX_REPORTS = 40;

    // one tick outcome, laid out as the result ports
    typedef struct packed {
        logic [2:0]  run_slot;
        logic        idle;
        logic        finished;
        logic [15:0] time_now;
        logic        all_done;
    } tick_result_t;

    // scoreboard: its own copy of the job table, the tick outcomes still owed
    class sched_scoreboard;
        logic [15:0]  work_left [SLOTS];
        logic [15:0]  arrive_at [SLOTS];
        logic [7:0]   prio_of   [SLOTS];
        logic [15:0]  clock_now;
        tick_result_t owed_q [$];
        int           mismatches;
        int           loads_seen;
        int           ticks_seen;
        int           idle_seen;
        int           finished_seen;
        int           all_done_seen;

        function new();
            foreach (work_left[k]) begin
                work_left[k] = '0;
                arrive_at[k] = '0;
                prio_of[k]   = '0;
            end
            clock_now     = '0;
            mismatches    = 0;
            loads_seen    = 0;
            ticks_seen    = 0;
            idle_seen     = 0;
            finished_seen = 0;
            all_done_seen = 0;
        endfunction

        function void flag(string msg);
            if (mismatches < MAX_REPORTS) begin
                $display("[%0t] MISMATCH: %s", $realtime, msg);
            end
            mismatches++;
        endfunction

        // one scheduling decision: best ready job, one unit of work, time moves on
        function tick_result_t serve_tick();
            tick_result_t r;
            bit           found;
            int           best;
            found = 1'b0;
            best  = 0;
            for (int k = 0; k < SLOTS; k++) begin
                if (work_left[k] != 0 && arrive_at[k] <= clock_now) begin
                    if (!found || prio_of[k] > prio_of[best] ||
                        (prio_of[k] == prio_of[best] && arrive_at[k] < arrive_at[best])) begin
                        found = 1'b1;
                        best  = k;
                    end
                end
            end
            r      = '0;
            r.idle = !found;
            if (found) begin
                work_left[best] = work_left[best] - 16'd1;
                r.run_slot      = 3'(best);
                r.finished      = (work_left[best] == 0);
            end
            if (clock_now != 16'hFFFF) begin
                clock_now = clock_now + 16'd1;
            end
            r.time_now = clock_now;
            r.all_done = 1'b1;
            for (int k = 0; k < SLOTS; k++) begin
                if (work_left[k] != 0) begin
                    r.all_done = 1'b0;
                end
            end
            ticks_seen    += 1;
            idle_seen     += r.idle;
            finished_seen += r.finished;
            all_done_seen += r.all_done;
            return r;
        endfunction

        function void note_word(logic func, logic [2:0] slot, logic [15:0] arrival,
                                logic [15:0] burst, logic [7:0] prio);
            if (func == FUNC_LOAD) begin
                arrive_at[slot] = arrival;
                work_left[slot] = burst;
                prio_of[slot]   = prio;
                loads_seen++;
            end else begin
                owed_q.push_back(serve_tick());
            end
        endfunction

        function void check_result(tick_result_t got);
            tick_result_t want;
            if (owed_q.size() == 0) begin
                flag($sformatf("result word with nothing owed (slot %0d time %0d)",
                               got.run_slot, got.time_now));
                return;
            end
            want = owed_q.pop_front();
            if (got.run_slot !== want.run_slot)
                flag($sformatf("run_slot %0d, expected %0d", got.run_slot, want.run_slot));
            if (got.idle !== want.idle)
                flag($sformatf("idle %0b, expected %0b", got.idle, want.idle));
            if (got.finished !== want.finished)
                flag($sformatf("finished %0b, expected %0b", got.finished, want.finished));
            if (got.time_now !== want.time_now)
                flag($sformatf("time_now %0d, expected %0d", got.time_now, want.time_now));
            if (got.all_done !== want.all_done)
                flag($sformatf("all_done %0b, expected %0b", got.all_done, want.all_done));
        endfunction
    endclass

    // block inputs, all known from time zero
    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        i_func         = 1'b0;
    logic [2:0]  i_slot         = '0;
    logic [15:0] i_arrival      = '0;
    logic [15:0] i_burst        = '0;
    logic [7:0]  i_priority_req = '0;
    logic        i_out_ready    = 1'b0;

    logic        o_in_ready;
    logic        o_out_valid;
    logic [2:0]  o_run_slot;
    logic        o_idle;
    logic        o_finished;
    logic [15:0] o_time_now;
    logic        o_all_done;

    sched_scoreboard sb;

    // stimulus-side view of time: ticks offered so far, saturating like the block
    logic [15:0] clock_sent    = '0;
    bit          tx_quiet      = 1'b0;   // sender offers words back to back
    bit          rx_quiet      = 1'b0;   // receiver never stalls
    bit          long_hold_req = 1'b0;   // asks the receiver for one long hold-off
    int          cycles_run    = 0;

    preemptive_priority_scheduler #(
        .SLOTS     (SLOTS),
        .TIME_BITS (16)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_slot         (i_slot),
        .i_arrival      (i_arrival),
        .i_burst        (i_burst),
        .i_priority_req (i_priority_req),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_run_slot     (o_run_slot),
        .o_idle         (o_idle),
        .o_finished     (o_finished),
        .o_time_now     (o_time_now),
        .o_all_done     (o_all_done)
    );

    initial begin : clock_gen
        forever begin
            #4 i_clk = ~i_clk;
        end
    end

    // run limit, far beyond the slowest correct run
    always @(posedge i_clk) begin
        cycles_run <= cycles_run + 1;
        if (cycles_run >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles_run);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // idle gap length: mostly none or short, now and then long
    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    // offer one word and hold it until taken; valid only drops when a gap follows
    task automatic send_word(input logic func, input logic [2:0] slot,
                             input logic [15:0] arrival, input logic [15:0] burst,
                             input logic [7:0] prio);
        int gap;
        gap = pick_gap(tx_quiet);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_func         <= func;
        i_slot         <= slot;
        i_arrival      <= arrival;
        i_burst        <= burst;
        i_priority_req <= prio;
        i_in_valid     <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (func == FUNC_TICK && clock_sent != 16'hFFFF) begin
            clock_sent = clock_sent + 16'd1;
        end
    endtask

    // tick word: the load fields are don't-care, so fill them with noise
    task automatic send_tick();
        send_word(FUNC_TICK, 3'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
    endtask

    // load word shaped so most jobs arrive close to the current time and finish
    task automatic send_random_load();
        int          r;
        int          a;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [7:0]  prio;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            a = int'(clock_sent) + $urandom_range(0, 8) - 4;
            if (a < 0) a = 0;
            if (a > 65535) a = 65535;
            arrival = 16'(a);
        end else if (r < 80) begin
            arrival = '0;
        end else if (r < 85) begin
            arrival = 16'hFFFF;
        end else begin
            arrival = 16'($urandom);
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            burst = 16'($urandom_range(1, 4));
        end else if (r < 75) begin
            burst = '0;
        end else if (r < 92) begin
            burst = 16'($urandom_range(5, 30));
        end else begin
            burst = 16'($urandom);
        end
        // a narrow priority range makes ties frequent
        r = $urandom_range(0, 99);
        if (r < 50) begin
            prio = 8'($urandom_range(0, 3));
        end else if (r < 65) begin
            prio = 8'hFF;
        end else begin
            prio = 8'($urandom);
        end
        send_word(FUNC_LOAD, 3'($urandom), arrival, burst, prio);
    endtask

    // accepted words feed the predictor; values sampled before this edge's updates
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            sb.note_word(i_func, i_slot, i_arrival, i_burst, i_priority_req);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result('{o_run_slot, o_idle, o_finished, o_time_now, o_all_done});
        end
    end

    // result side back-pressure, with one long hold-off on request
    initial begin : result_sink
        int stall;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                stall = pick_gap(rx_quiet);
                if (stall == 0) begin
                    i_out_ready <= 1'b1;
                end else begin
                    i_out_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                    i_out_ready <= 1'b1;
                end
            end
        end
    end

    initial begin : stimulus
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table first, an idle tick with nothing left anywhere
        send_tick();
        send_word(FUNC_LOAD, 3'd0, 16'd0, 16'd2, 8'd5);
        send_word(FUNC_LOAD, 3'd3, 16'd0, 16'd1, 8'd5);          // same priority and arrival as slot 0
        send_word(FUNC_LOAD, 3'd1, 16'd1, 16'd1, 8'd5);
        send_word(FUNC_LOAD, 3'd4, 16'd0, 16'd1, 8'd5);          // earlier arrival beats lower slot 1
        send_word(FUNC_LOAD, 3'd2, 16'd3, 16'd1, 8'hFF);         // top priority, turns up later and preempts
        send_word(FUNC_LOAD, 3'd7, 16'hFFFF, 16'hFFFF, 8'hFF);   // far future job at the field maxima
        send_word(FUNC_LOAD, 3'd6, 16'd0, 16'd0, 8'hFF);         // empty slot, priority must not matter
        repeat (3) send_tick();
        send_word(FUNC_LOAD, 3'd0, 16'd0, 16'd3, 8'd0);          // reload of a slot whose job has finished
        repeat (6) send_tick();
        send_word(FUNC_LOAD, 3'd7, 16'd0, 16'd0, 8'd0);          // clear the far future job
        repeat (3) send_tick();                                  // every one idles, with all-done set

        // random words, with one pressure window and a few stretches without gaps
        for (int n = 0; n < RAND_WORDS; n++) begin
            if (n == RAND_WORDS / 2) begin
                long_hold_req = 1'b1;
                tx_quiet      = 1'b1;
            end
            if (n == RAND_WORDS / 2 + PRESS_WORDS) begin
                tx_quiet = 1'b0;
            end
            if (n % 500 == 200) begin
                tx_quiet = 1'b1;
                rx_quiet = 1'b1;
            end
            if (n % 500 == 260) begin
                tx_quiet = 1'b0;
                rx_quiet = 1'b0;
            end
            if (n >= RAND_WORDS / 2 && n < RAND_WORDS / 2 + PRESS_WORDS) begin
                send_tick();
            end else if ($urandom_range(0, 99) < 45) begin
                send_tick();
            end else begin
                send_random_load();
            end
        end

        // finish at full speed with only late jobs left, so every tick idles
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        for (int k = 0; k < 5; k++) begin
            send_word(FUNC_LOAD, 3'(k), 16'($urandom), 16'd0, 8'($urandom));
        end
        send_word(FUNC_LOAD, 3'd5, 16'hFFFF, 16'd1, 8'd200);     // same priority as slot 7, later arrival
        send_word(FUNC_LOAD, 3'd6, 16'hFFFF, 16'd3, 8'd10);
        send_word(FUNC_LOAD, 3'd7, 16'hFFFE, 16'd2, 8'd200);
        repeat (20) send_tick();
        i_in_valid <= 1'b0;

        while (sb.owed_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (sb.owed_q.size() != 0) begin
            sb.flag($sformatf("%0d tick results never arrived", sb.owed_q.size()));
        end

        $display("covered %0d load words and %0d ticks: %0d idle, %0d completions, %0d all-done",
                 sb.loads_seen, sb.ticks_seen, sb.idle_seen, sb.finished_seen,
                 sb.all_done_seen);
        $display("scheduler time reached %0d in %0d cycles, %0d mismatches",
                 sb.clock_now, cycles_run, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
